// File: rtl/euc_to_jis_escape_encoder_unit_macros.svh
// assertion helpers shared by the encoder modules
// each expects clk and rst in the scope where it is used
`ifndef EUC_TO_JIS_ESCAPE_ENCODER_UNIT_MACROS_SVH
`define EUC_TO_JIS_ESCAPE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define ETJE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("etje check failed");

// next-cycle implication
`define ETJE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("etje check failed");

`endif

// File: rtl/etje_pkg.sv
package etje_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] LOW7_MASK   = 8'h7f;
  localparam logic [7:0] KANJI_INTRO = 8'h24;
  localparam logic [7:0] ASCII_INTRO = 8'h28;
  localparam logic [7:0] LEAD_MIN    = 8'ha1;
  localparam logic [7:0] LEAD_MAX    = 8'hfe;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_KANJI_FINAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCII_FINAL = 8'd1;

  localparam logic [7:0] KANJI_FINAL_RST = 8'h40;
  localparam logic [7:0] ASCII_FINAL_RST = 8'h4a;

  localparam logic [1:0] IDX_SINGLE = 2'd0;
  localparam logic [1:0] IDX_ESCAPED = 2'd3;

  // one input's worth of output bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } group_t;

  typedef struct packed {
    logic kanji_mode;
    logic second_pending;
  } mode_t;

endpackage

// File: rtl/etje_in_if.sv
interface etje_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/etje_out_if.sv
interface etje_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/etje_cfg_if.sv
interface etje_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [etje_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/etje_decode.sv
module etje_decode (
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  etje_pkg::mode_t  mode,
  input  logic [7:0]       kanji_final,
  input  logic [7:0]       ascii_final,
  output etje_pkg::group_t grp,
  output etje_pkg::mode_t  mode_next
);

  logic [7:0] low7;
  logic       is_lead;

  assign low7    = in_byte & etje_pkg::LOW7_MASK;
  assign is_lead = (in_byte >= etje_pkg::LEAD_MIN) && (in_byte <= etje_pkg::LEAD_MAX);

  always_comb begin
    grp       = '0;
    mode_next = mode;
    if (mode.second_pending) begin
      grp.bytes[0] = low7;
      mode_next.second_pending = 1'b0;
      if (in_last && mode.kanji_mode) begin
        grp.bytes[1] = etje_pkg::ESC_BYTE;
        grp.bytes[2] = etje_pkg::ASCII_INTRO;
        grp.bytes[3] = ascii_final;
        grp.last_idx = etje_pkg::IDX_ESCAPED;
      end
    end else if (in_last || !is_lead) begin
      // raw byte, closing kanji mode first if open
      if (mode.kanji_mode) begin
        grp.bytes[0] = etje_pkg::ESC_BYTE;
        grp.bytes[1] = etje_pkg::ASCII_INTRO;
        grp.bytes[2] = ascii_final;
        grp.bytes[3] = in_byte;
        grp.last_idx = etje_pkg::IDX_ESCAPED;
      end else begin
        grp.bytes[0] = in_byte;
        grp.last_idx = etje_pkg::IDX_SINGLE;
      end
      mode_next.kanji_mode = 1'b0;
    end else begin
      // lead byte of a pair
      if (!mode.kanji_mode) begin
        grp.bytes[0] = etje_pkg::ESC_BYTE;
        grp.bytes[1] = etje_pkg::KANJI_INTRO;
        grp.bytes[2] = kanji_final;
        grp.bytes[3] = low7;
        grp.last_idx = etje_pkg::IDX_ESCAPED;
      end else begin
        grp.bytes[0] = low7;
        grp.last_idx = etje_pkg::IDX_SINGLE;
      end
      mode_next.kanji_mode     = 1'b1;
      mode_next.second_pending = 1'b1;
    end
    if (in_last) begin
      mode_next = '0;
    end
  end

endmodule

// File: rtl/etje_emit.sv
`include "euc_to_jis_escape_encoder_unit_macros.svh"

module etje_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  etje_pkg::group_t grp_in,
  output logic             free,
  etje_out_if.source       down
);

  etje_pkg::group_t grp;
  logic             grp_valid;
  logic [1:0]       idx;
  logic             at_last;

  assign at_last = (idx == grp.last_idx);
  // slot frees up when empty or its final byte leaves this cycle
  assign free    = !grp_valid || (down.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (grp_valid && down.ready) begin
      if (at_last) begin
        grp_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  assign down.valid    = grp_valid;
  assign down.out_byte = grp.bytes[idx];
  assign down.out_last = at_last;

  `ETJE_ASSERT_NOW(a_idx_in_group, grp_valid, idx <= grp.last_idx)
  `ETJE_ASSERT_NEXT(a_group_holds, grp_valid && down.ready && !at_last, grp_valid)
  `ETJE_ASSERT_NOW(a_load_when_free, load, free)

endmodule

// File: rtl/euc_to_jis_escape_encoder_unit.sv
// EUC-JP to 7-bit JIS encoder. One EUC-JP byte per input beat, one JIS byte per output
// beat; out_last marks the final byte caused by an input beat. An input byte yields one
// output byte, or four when an ESC $ / ESC ( shift sequence goes in front of or after it;
// the output byte register drains one byte a cycle while down.ready is high and
// is refilled in the cycle its final byte leaves. An input byte goes from accept to its
// first output byte through the input register, then the output group register. An input
// register takes the next byte while a group is still draining. Configuration writes
// are taken every cycle: index 0 sets the kanji final byte (reset '@'), index 1 the ascii
// final byte (reset 'J'); other indexes are ignored. Write only while idle.
`include "euc_to_jis_escape_encoder_unit_macros.svh"

module euc_to_jis_escape_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  etje_in_if.sink    up,
  etje_out_if.source down,
  etje_cfg_if.sink   cfg
);

  logic             ib_valid;
  logic [7:0]       ib_byte;
  logic             ib_last;
  logic             load;
  logic             free;
  logic [7:0]       kanji_final;
  logic [7:0]       ascii_final;
  etje_pkg::mode_t  mode;
  etje_pkg::mode_t  mode_next;
  etje_pkg::group_t grp_next;

  assign load     = ib_valid && free;
  assign up.ready = !ib_valid || load;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (up.valid && up.ready) begin
      ib_valid <= 1'b1;
    end else if (load) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      ib_byte <= up.in_byte;
      ib_last <= up.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (load) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kanji_final <= etje_pkg::KANJI_FINAL_RST;
      ascii_final <= etje_pkg::ASCII_FINAL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        etje_pkg::CFG_KANJI_FINAL: kanji_final <= cfg.data;
        etje_pkg::CFG_ASCII_FINAL: ascii_final <= cfg.data;
        default: ;
      endcase
    end
  end

  etje_decode u_decode (
    .in_byte     (ib_byte),
    .in_last     (ib_last),
    .mode        (mode),
    .kanji_final (kanji_final),
    .ascii_final (ascii_final),
    .grp         (grp_next),
    .mode_next   (mode_next)
  );

  etje_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .grp_in (grp_next),
    .free   (free),
    .down   (down)
  );

  // a pair half is only ever pending inside kanji mode
  `ETJE_ASSERT_NOW(a_pending_in_kanji, mode.second_pending, mode.kanji_mode)
  `ETJE_ASSERT_NEXT(a_run_end_clears, load && ib_last, mode == '0)
  `ETJE_ASSERT_NEXT(a_mode_held, !load, mode == $past(mode))

endmodule
